>>> rtl/core/ptmi_pkg.sv
// Shared constants, types and helper functions of the page table map/insert unit.
package ptmi_pkg;

    localparam int POOL_FRAMES       = 16;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int PAGE_SIZES        = 5;

    localparam int PPN_W   = 44;
    localparam int VPN_W   = 45;
    localparam int IDX_W   = 9;
    localparam int LVL_W   = 3;
    localparam int ENTRY_W = 64;
    localparam int CFG_W   = 44;
    localparam int CFG_IDX_W = 3;

    localparam int STORE_DEPTH = POOL_FRAMES * ENTRIES_PER_TABLE;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int FIDX_W      = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
    localparam int CNT_W       = $clog2(POOL_FRAMES + 1);

    localparam logic [7:0] FLAG_V = 8'h01;
    localparam logic [7:0] FLAG_R = 8'h02;
    localparam logic [7:0] FLAG_W = 8'h04;
    localparam logic [7:0] FLAG_X = 8'h08;
    localparam logic [7:0] FLAG_G = 8'h20;

    localparam logic [1:0] CMD_NEW_ROOT  = 2'd0;
    localparam logic [1:0] CMD_MAP_GIVEN = 2'd1;
    localparam logic [1:0] CMD_MAP_ALLOC = 2'd2;
    localparam logic [1:0] CMD_UNUSED    = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_LEVEL     = 2'd2;
    localparam logic [1:0] ST_OUTSIDE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_LEVELS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE3  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE4  = 3'd5;

    // One store word: the entry plus its bookkeeping tag.
    typedef struct packed {
        logic                written;
        logic                epoch;
        logic [ENTRY_W-1:0]  value;
    } store_word_t;

    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        store_word_t        data;
    } store_wr_t;

    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
    } store_rd_t;

    // Frame offset n * 512^lvl within a pool.
    function automatic logic [PPN_W-1:0] frame_offset(input logic [CNT_W-1:0] n,
                                                      input logic [LVL_W-1:0] lvl);
        logic [PPN_W-1:0] wide;
        wide = PPN_W'(n);
        case (lvl)
            3'd0:    frame_offset = wide;
            3'd1:    frame_offset = wide << 9;
            3'd2:    frame_offset = wide << 18;
            3'd3:    frame_offset = wide << 27;
            3'd4:    frame_offset = wide << 36;
            default: frame_offset = '0;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] vpn_index(input logic [VPN_W-1:0] vpn,
                                                   input logic [LVL_W-1:0] lvl);
        case (lvl)
            3'd0:    vpn_index = vpn[8:0];
            3'd1:    vpn_index = vpn[17:9];
            3'd2:    vpn_index = vpn[26:18];
            3'd3:    vpn_index = vpn[35:27];
            3'd4:    vpn_index = vpn[44:36];
            default: vpn_index = '0;
        endcase
    endfunction

    function automatic logic [ENTRY_W-1:0] make_entry(input logic [7:0] flags,
                                                      input logic [PPN_W-1:0] ppn);
        make_entry = {10'b0, ppn, 2'b00, flags};
    endfunction

endpackage

>>> rtl/core/ptmi_alu.sv
// Shared page number adder/subtractor used for frame allocation and store lookup.
module ptmi_alu
    import ptmi_pkg::*;
(
    input  logic             sub,
    input  logic [PPN_W-1:0] a,
    input  logic [PPN_W-1:0] b,
    output logic [PPN_W-1:0] y
);

    always_comb
    begin
        if (sub)
        begin
            y = a - b;
        end
        else
        begin
            y = a + b;
        end
    end

endmodule

>>> rtl/core/ptmi_store.sv
// Table store memory with a clearing pass over the tag bits after reset.
module ptmi_store
    import ptmi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  store_wr_t   wr,
    input  store_rd_t   rd,
    output store_word_t rd_data,
    output logic        busy
);

    store_word_t mem [STORE_DEPTH];

    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic              busy_reg;
    logic              busy_next;
    store_wr_t         port;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        busy_next     = busy_reg;
        port          = wr;
        if (busy_reg)
        begin
            port.en   = 1'b1;
            port.addr = clr_addr_reg;
            port.data = '0;
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            busy_reg     <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (port.en)
        begin
            mem[port.addr] <= port.data;
        end
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

    assign busy = busy_reg;

endmodule

>>> rtl/core/page_table_map_insert_unit.sv
// Top level: command sequencer of the page table builder around the shared adder and store.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_stall, cmd .. executable     | in
//  output  | out_valid, out_stall, status .. last_result| out
//  config  | cfg_write, cfg_index, cfg_data            | in
//
// After the accepting cycle a command runs leaf allocation (S_LEAF_ALLOC) when it asks for
// one, then on each level reads the entry (S_FRAME, S_ENTRY) and descends if it is valid, or
// allocates and links a table (S_ALLOC, S_LINK) if not; the leaf level takes S_FRAME and
// S_LEAF. A new root (S_ROOT) or an early error (S_ERR) goes straight to its result.
// After reset the store tags are cleared one entry a cycle while in_stall stays high. A result
// waits in the output register while out_stall is high, and a state that makes a result holds
// until the register is free.
module page_table_map_insert_unit
    import ptmi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           cmd,
    input  logic [VPN_W-1:0]     virtual_page,
    input  logic [PPN_W-1:0]     physical_page,
    input  logic [LVL_W-1:0]     page_level,
    input  logic                 readable,
    input  logic                 writable,
    input  logic                 executable,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic [PPN_W-1:0]     table_page,
    output logic [IDX_W-1:0]     entry_index,
    output logic [ENTRY_W-1:0]   entry_value,
    output logic                 entry_written,
    output logic                 last_result
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROOT,
        S_LEAF_ALLOC,
        S_FRAME,
        S_ENTRY,
        S_ALLOC,
        S_LINK,
        S_LEAF,
        S_ERR
    } state_t;

    state_t              state_reg;
    logic [2:0]          levels_reg;
    logic [PPN_W-1:0]    base_reg [PAGE_SIZES];
    logic [CNT_W-1:0]    cnt_reg [PAGE_SIZES];
    logic [PPN_W-1:0]    root_reg;
    logic                root_present_reg;
    logic [POOL_FRAMES-1:0] zeroed_reg;

    logic [VPN_W-1:0]    vpn_reg;
    logic [LVL_W-1:0]    ps_reg;
    logic [2:0]          rwx_reg;
    logic [LVL_W-1:0]    lvl_reg;
    logic [PPN_W-1:0]    leaf_ppn_reg;
    logic [PPN_W-1:0]    cur_reg;
    logic [PPN_W-1:0]    new_reg;
    logic [FIDX_W-1:0]   k_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [1:0]          err_reg;

    logic                out_valid_reg;
    logic [1:0]          status_reg;
    logic [PPN_W-1:0]    table_page_reg;
    logic [IDX_W-1:0]    entry_index_reg;
    logic [ENTRY_W-1:0]  entry_value_reg;
    logic                entry_written_reg;
    logic                last_result_reg;

    logic                alu_sub;
    logic [PPN_W-1:0]    alu_a;
    logic [PPN_W-1:0]    alu_b;
    logic [PPN_W-1:0]    alu_y;

    store_wr_t           st_wr;
    store_rd_t           st_rd;
    store_word_t         st_rd_data;
    logic                st_busy;

    logic [LVL_W-1:0]    top_lvl;
    logic                in_xfer;
    logic                out_xfer;
    logic                out_free;
    logic                k_zeroed;
    logic [ENTRY_W-1:0]  rd_entry;
    logic [ADDR_W-1:0]   slot_addr;
    logic [7:0]          leaf_flags;

    ptmi_alu u_alu (
        .sub (alu_sub),
        .a   (alu_a),
        .b   (alu_b),
        .y   (alu_y)
    );

    ptmi_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (st_wr),
        .rd      (st_rd),
        .rd_data (st_rd_data),
        .busy    (st_busy)
    );

    always_comb
    begin
        if (levels_reg < 3'd3)
        begin
            top_lvl = 3'd2;
        end
        else if (levels_reg > 3'd5)
        begin
            top_lvl = 3'd4;
        end
        else
        begin
            top_lvl = levels_reg - 3'd1;
        end
    end

    assign in_stall = (state_reg != S_IDLE) || st_busy;
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg;

    // A frame is zeroed once, when it is taken as a table; writes made before that are stale.
    // A 4 KiB frame taken as a leaf page is not zeroed.
    assign k_zeroed  = zeroed_reg[k_reg];
    assign rd_entry  = (st_rd_data.written && (st_rd_data.epoch == k_zeroed))
                       ? st_rd_data.value : '0;
    assign slot_addr = ADDR_W'({k_reg, idx_reg});
    assign leaf_flags = FLAG_V | FLAG_G | (rwx_reg[0] ? FLAG_R : 8'h00)
                        | (rwx_reg[1] ? FLAG_W : 8'h00) | (rwx_reg[2] ? FLAG_X : 8'h00);

    // Shared adder: allocation adds a pool offset, lookup subtracts the pool-0 base.
    always_comb
    begin
        alu_sub = 1'b0;
        alu_a   = base_reg[0];
        alu_b   = frame_offset(cnt_reg[0], 3'd0);
        case (state_reg)
            S_LEAF_ALLOC:
            begin
                alu_a = base_reg[ps_reg];
                alu_b = frame_offset(cnt_reg[ps_reg], ps_reg);
            end
            S_FRAME:
            begin
                alu_sub = 1'b1;
                alu_a   = cur_reg;
                alu_b   = base_reg[0];
            end
            default:
            begin
                alu_sub = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        st_rd.en    = (state_reg == S_FRAME) && (alu_y < PPN_W'(POOL_FRAMES))
                      && (lvl_reg != ps_reg);
        st_rd.addr  = ADDR_W'({alu_y[FIDX_W-1:0], vpn_index(vpn_reg, lvl_reg)});
        st_wr.en    = 1'b0;
        st_wr.addr  = slot_addr;
        st_wr.data.written = 1'b1;
        st_wr.data.epoch   = k_zeroed;
        st_wr.data.value   = make_entry(leaf_flags, leaf_ppn_reg);
        if (state_reg == S_LINK)
        begin
            st_wr.en         = out_free;
            st_wr.data.value = make_entry(FLAG_V | FLAG_G, new_reg);
        end
        else if (state_reg == S_LEAF)
        begin
            st_wr.en = out_free;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            levels_reg       <= 3'd3;
            root_reg         <= '0;
            root_present_reg <= 1'b0;
            zeroed_reg       <= '0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < PAGE_SIZES; i++)
            begin
                base_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_LEVELS: levels_reg  <= cfg_data[2:0];
                    REG_BASE0:  base_reg[0] <= cfg_data;
                    REG_BASE1:  base_reg[1] <= cfg_data;
                    REG_BASE2:  base_reg[2] <= cfg_data;
                    REG_BASE3:  base_reg[3] <= cfg_data;
                    REG_BASE4:  base_reg[4] <= cfg_data;
                    default:    levels_reg  <= levels_reg;
                endcase
            end

            if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        vpn_reg       <= virtual_page;
                        ps_reg        <= page_level;
                        rwx_reg       <= {executable, writable, readable};
                        lvl_reg       <= top_lvl;
                        cur_reg       <= root_reg;
                        leaf_ppn_reg  <= physical_page;
                        case (cmd)
                            CMD_NEW_ROOT:
                            begin
                                state_reg <= S_ROOT;
                            end
                            CMD_MAP_GIVEN, CMD_MAP_ALLOC:
                            begin
                                if (page_level > top_lvl)
                                begin
                                    err_reg   <= ST_LEVEL;
                                    state_reg <= S_ERR;
                                end
                                else if (!root_present_reg)
                                begin
                                    err_reg   <= ST_OUTSIDE;
                                    state_reg <= S_ERR;
                                end
                                else if (cmd == CMD_MAP_ALLOC)
                                begin
                                    state_reg <= S_LEAF_ALLOC;
                                end
                                else
                                begin
                                    state_reg <= S_FRAME;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end

                S_ROOT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        entry_index_reg   <= '0;
                        entry_value_reg   <= '0;
                        entry_written_reg <= 1'b0;
                        last_result_reg   <= 1'b1;
                        if (cnt_reg[0] >= CNT_W'(POOL_FRAMES))
                        begin
                            status_reg     <= ST_EXHAUSTED;
                            table_page_reg <= '0;
                        end
                        else
                        begin
                            status_reg       <= ST_OK;
                            table_page_reg   <= alu_y;
                            root_reg         <= alu_y;
                            root_present_reg <= 1'b1;
                            zeroed_reg[cnt_reg[0][FIDX_W-1:0]] <= 1'b1;
                            cnt_reg[0]       <= cnt_reg[0] + CNT_W'(1);
                        end
                        state_reg <= S_IDLE;
                    end
                end

                S_LEAF_ALLOC:
                begin
                    if ((ps_reg >= LVL_W'(PAGE_SIZES)) ||
                        (cnt_reg[ps_reg] >= CNT_W'(POOL_FRAMES)))
                    begin
                        err_reg   <= ST_EXHAUSTED;
                        state_reg <= S_ERR;
                    end
                    else
                    begin
                        leaf_ppn_reg    <= alu_y;
                        cnt_reg[ps_reg] <= cnt_reg[ps_reg] + CNT_W'(1);
                        state_reg       <= S_FRAME;
                    end
                end

                S_FRAME:
                begin
                    if (alu_y >= PPN_W'(POOL_FRAMES))
                    begin
                        err_reg   <= ST_OUTSIDE;
                        state_reg <= S_ERR;
                    end
                    else
                    begin
                        k_reg   <= alu_y[FIDX_W-1:0];
                        idx_reg <= vpn_index(vpn_reg, lvl_reg);
                        if (lvl_reg == ps_reg)
                        begin
                            state_reg <= S_LEAF;
                        end
                        else
                        begin
                            state_reg <= S_ENTRY;
                        end
                    end
                end

                S_ENTRY:
                begin
                    if (rd_entry[0])
                    begin
                        cur_reg   <= rd_entry[53:10];
                        lvl_reg   <= lvl_reg - LVL_W'(1);
                        state_reg <= S_FRAME;
                    end
                    else
                    begin
                        state_reg <= S_ALLOC;
                    end
                end

                S_ALLOC:
                begin
                    if (cnt_reg[0] >= CNT_W'(POOL_FRAMES))
                    begin
                        err_reg   <= ST_EXHAUSTED;
                        state_reg <= S_ERR;
                    end
                    else
                    begin
                        new_reg    <= alu_y;
                        zeroed_reg[cnt_reg[0][FIDX_W-1:0]] <= 1'b1;
                        cnt_reg[0] <= cnt_reg[0] + CNT_W'(1);
                        state_reg  <= S_LINK;
                    end
                end

                S_LINK:
                begin
                    if (out_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        status_reg        <= ST_OK;
                        table_page_reg    <= cur_reg;
                        entry_index_reg   <= idx_reg;
                        entry_value_reg   <= make_entry(FLAG_V | FLAG_G, new_reg);
                        entry_written_reg <= 1'b1;
                        last_result_reg   <= 1'b0;
                        cur_reg           <= new_reg;
                        lvl_reg           <= lvl_reg - LVL_W'(1);
                        state_reg         <= S_FRAME;
                    end
                end

                S_LEAF:
                begin
                    if (out_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        status_reg        <= ST_OK;
                        table_page_reg    <= cur_reg;
                        entry_index_reg   <= idx_reg;
                        entry_value_reg   <= make_entry(leaf_flags, leaf_ppn_reg);
                        entry_written_reg <= 1'b1;
                        last_result_reg   <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                end

                S_ERR:
                begin
                    if (out_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        status_reg        <= err_reg;
                        table_page_reg    <= '0;
                        entry_index_reg   <= '0;
                        entry_value_reg   <= '0;
                        entry_written_reg <= 1'b0;
                        last_result_reg   <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign table_page    = table_page_reg;
    assign entry_index   = entry_index_reg;
    assign entry_value   = entry_value_reg;
    assign entry_written = entry_written_reg;
    assign last_result   = last_result_reg;

endmodule

>>> test/tb_page_table_map_insert_unit.sv
// Self-checking testbench of the page table map/insert unit with its own table-walk predictor.
module tb_page_table_map_insert_unit;
    import ptmi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 40000;
    localparam int LONG_HOLD  = 400;
    localparam int TAIL       = 60;

    typedef struct {
        logic [1:0]       op;
        logic [VPN_W-1:0] vpn;
        logic [PPN_W-1:0] ppn;
        logic [LVL_W-1:0] lvl;
        logic             rd;
        logic             wr;
        logic             ex;
    } map_req_t;

    typedef struct {
        logic [1:0]         st;
        logic [PPN_W-1:0]   tpg;
        logic [IDX_W-1:0]   idx;
        logic [ENTRY_W-1:0] val;
        logic               wrote;
        logic               last;
    } pte_write_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] cmd = '0;
    logic [VPN_W-1:0] virtual_page = '0;
    logic [PPN_W-1:0] physical_page = '0;
    logic [LVL_W-1:0] page_level = '0;
    logic readable = 1'b0;
    logic writable = 1'b0;
    logic executable = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] status;
    logic [PPN_W-1:0] table_page;
    logic [IDX_W-1:0] entry_index;
    logic [ENTRY_W-1:0] entry_value;
    logic entry_written;
    logic last_result;

    page_table_map_insert_unit u_dut (.*);

    always #2 clk = ~clk;

    // Predictor state: shadow of the table store, the pools and the registers.
    logic [ENTRY_W-1:0] pt_mem [STORE_DEPTH];
    bit                 pt_known [STORE_DEPTH];
    int unsigned        pool_used [PAGE_SIZES];
    logic [PPN_W-1:0]   pool_base [PAGE_SIZES];
    logic [PPN_W-1:0]   root_pg;
    bit                 has_root;
    logic [2:0]         levels_reg;

    map_req_t   pend_q [$];
    pte_write_t pte_q [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_ask = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int errors = 0;
    int n_sent = 0;
    int n_results = 0;
    int n_status [4];
    int idle_cycles = 0;
    map_req_t drv_req;

    function automatic int top_level();
        if (levels_reg < 3)
            return 2;
        if (levels_reg > 5)
            return 4;
        return int'(levels_reg) - 1;
    endfunction

    function automatic bit take_frame(input int lv, output logic [PPN_W-1:0] pg);
        logic [PPN_W-1:0] off;
        if (pool_used[lv] >= POOL_FRAMES)
            return 0;
        off = PPN_W'(pool_used[lv]) << (9 * lv);
        pg = pool_base[lv] + off;
        pool_used[lv]++;
        return 1;
    endfunction

    function automatic int frame_of(input logic [PPN_W-1:0] pg);
        logic [PPN_W-1:0] k;
        k = pg - pool_base[0];
        return (k < POOL_FRAMES) ? int'(k) : POOL_FRAMES;
    endfunction

    function automatic void clear_frame(input logic [PPN_W-1:0] pg);
        int k;
        k = frame_of(pg);
        if (k >= POOL_FRAMES)
            return;
        for (int i = 0; i < ENTRIES_PER_TABLE; i++) begin
            pt_mem[k * ENTRIES_PER_TABLE + i] = '0;
            pt_known[k * ENTRIES_PER_TABLE + i] = 1;
        end
    endfunction

    // A walk must never read a store entry the block has not written yet.
    function automatic bit walk_is_defined(input map_req_t r);
        logic [PPN_W-1:0] cur;
        logic [ENTRY_W-1:0] pte;
        int k;
        int slot;
        if (r.op == CMD_NEW_ROOT || r.op == CMD_UNUSED)
            return 1;
        if (int'(r.lvl) > top_level() || !has_root)
            return 1;
        if (r.op == CMD_MAP_ALLOC && pool_used[r.lvl] >= POOL_FRAMES)
            return 1;
        cur = root_pg;
        for (int l = top_level(); l > int'(r.lvl); l--) begin
            k = frame_of(cur);
            if (k >= POOL_FRAMES)
                return 1;
            slot = k * ENTRIES_PER_TABLE + int'((r.vpn >> (9 * l)) & 'h1ff);
            if (!pt_known[slot])
                return 0;
            pte = pt_mem[slot];
            if (!pte[0])
                return 1;
            cur = pte[10 +: PPN_W];
        end
        return 1;
    endfunction

    function automatic void predict_map(input map_req_t r);
        pte_write_t outs [$];
        pte_write_t w;
        logic [PPN_W-1:0] cur;
        logic [PPN_W-1:0] pg;
        logic [PPN_W-1:0] leaf_pg;
        logic [ENTRY_W-1:0] pte;
        logic [IDX_W-1:0] ix;
        logic [7:0] flags;
        int k;
        int slot;
        bit failed;
        w = '{ST_OK, '0, '0, '0, 1'b0, 1'b0};
        leaf_pg = r.ppn;
        slot = 0;
        ix = '0;
        if (r.op == CMD_UNUSED)
            return;
        if (r.op == CMD_NEW_ROOT) begin
            if (take_frame(0, pg)) begin
                clear_frame(pg);
                root_pg = pg;
                has_root = 1;
                w.tpg = pg;
            end else
                w.st = ST_EXHAUSTED;
            outs.push_back(w);
        end else if (int'(r.lvl) > top_level()) begin
            w.st = ST_LEVEL;
            outs.push_back(w);
        end else if (!has_root) begin
            w.st = ST_OUTSIDE;
            outs.push_back(w);
        end else if (r.op == CMD_MAP_ALLOC && !take_frame(int'(r.lvl), leaf_pg)) begin
            w.st = ST_EXHAUSTED;
            outs.push_back(w);
        end else begin
            failed = 0;
            cur = root_pg;
            for (int l = top_level(); ; l--) begin
                k = frame_of(cur);
                if (k >= POOL_FRAMES) begin
                    w.st = ST_OUTSIDE;
                    outs.push_back(w);
                    failed = 1;
                    break;
                end
                ix = IDX_W'(r.vpn >> (9 * l));
                slot = k * ENTRIES_PER_TABLE + int'(ix);
                if (l == int'(r.lvl))
                    break;
                pte = pt_known[slot] ? pt_mem[slot] : '0;
                if (!pte[0]) begin
                    if (!take_frame(0, pg)) begin
                        w.st = ST_EXHAUSTED;
                        outs.push_back(w);
                        failed = 1;
                        break;
                    end
                    clear_frame(pg);
                    pte = {10'b0, pg, 2'b00, FLAG_V | FLAG_G};
                    pt_mem[slot] = pte;
                    pt_known[slot] = 1;
                    outs.push_back('{ST_OK, cur, ix, pte, 1'b1, 1'b0});
                end
                cur = pte[10 +: PPN_W];
            end
            if (!failed) begin
                flags = FLAG_V | FLAG_G;
                if (r.rd) flags |= FLAG_R;
                if (r.wr) flags |= FLAG_W;
                if (r.ex) flags |= FLAG_X;
                pte = {10'b0, leaf_pg, 2'b00, flags};
                pt_mem[slot] = pte;
                pt_known[slot] = 1;
                outs.push_back('{ST_OK, cur, ix, pte, 1'b1, 1'b0});
            end
        end
        outs[outs.size() - 1].last = 1'b1;
        foreach (outs[i])
            pte_q.push_back(outs[i]);
    endfunction

    function automatic map_req_t mk_req(input logic [1:0] op, input logic [VPN_W-1:0] vpn,
                                        input logic [PPN_W-1:0] ppn, input int lvl,
                                        input int rwx);
        map_req_t r;
        r.op = op;
        r.vpn = vpn;
        r.ppn = ppn;
        r.lvl = LVL_W'(lvl);
        r.rd = rwx[0];
        r.wr = rwx[1];
        r.ex = rwx[2];
        return r;
    endfunction

    // Most walks stay in a few address regions so that tables get reused.
    function automatic map_req_t rand_req();
        map_req_t r;
        int u;
        u = $urandom_range(0, 99);
        r.op = (u < 4) ? CMD_NEW_ROOT : (u < 8) ? CMD_UNUSED :
               (u < 55) ? CMD_MAP_GIVEN : CMD_MAP_ALLOC;
        if ($urandom_range(0, 3) == 0)
            r.vpn = VPN_W'({$urandom, $urandom});
        else
            r.vpn = (VPN_W'($urandom_range(0, 2)) << 36) | (VPN_W'($urandom_range(0, 2)) << 27)
                  | (VPN_W'($urandom_range(0, 3)) << 18) | (VPN_W'($urandom_range(0, 3)) << 9)
                  | VPN_W'($urandom_range(0, 511));
        r.ppn = PPN_W'({$urandom, $urandom});
        r.lvl = ($urandom_range(0, 9) == 0) ? LVL_W'($urandom_range(0, 7))
                                             : LVL_W'($urandom_range(0, 2));
        r.rd = $urandom_range(0, 1);
        r.wr = $urandom_range(0, 1);
        r.ex = $urandom_range(0, 1);
        return r;
    endfunction

    function automatic void queue_req(input map_req_t r);
        if (!walk_is_defined(r))
            return;
        predict_map(r);
        pend_q.push_back(r);
    endfunction

    task automatic queue_random(input int count);
        map_req_t r;
        for (int i = 0; i < count; i++) begin
            r = rand_req();
            for (int t = 0; t < 20 && !walk_is_defined(r); t++)
                r = rand_req();
            if (!walk_is_defined(r))
                r.op = CMD_NEW_ROOT;
            queue_req(r);
        end
    endtask

    task automatic drain();
        while (pend_q.size() != 0 || in_valid || pte_q.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_LEVELS)
            levels_reg = val[2:0];
        else
            pool_base[int'(idx) - 1] = val;
    endtask

    // Sender: offers the pending items, idling at random.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall) begin
            if (in_valid)
                n_sent <= n_sent + 1;
            if (pend_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                drv_req = pend_q.pop_front();
                cmd <= drv_req.op;
                virtual_page <= drv_req.vpn;
                physical_page <= drv_req.ppn;
                page_level <= drv_req.lvl;
                readable <= drv_req.rd;
                writable <= drv_req.wr;
                executable <= drv_req.ex;
                in_valid <= 1'b1;
            end else
                in_valid <= 1'b0;
        end
    end

    // Receiver: stalls at random or for one long hold, and checks every transfer.
    always @(posedge clk or negedge rst_n) begin
        pte_write_t e;
        if (!rst_n)
            out_stall <= 1'b0;
        else begin
            if (out_valid && !out_stall) begin
                n_results <= n_results + 1;
                n_status[status] <= n_status[status] + 1;
                if (pte_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result status=%0d page=%h index=%0d entry=%h",
                             $time, status, table_page, entry_index, entry_value);
                end else begin
                    e = pte_q.pop_front();
                    if (status !== e.st || table_page !== e.tpg || entry_index !== e.idx ||
                        entry_value !== e.val || entry_written !== e.wrote ||
                        last_result !== e.last) begin
                        errors++;
                        $display("%0t: mismatch expected st=%0d page=%h idx=%0d entry=%h wr=%b last=%b",
                                 $time, e.st, e.tpg, e.idx, e.val, e.wrote, e.last);
                        $display("%0t:          actual   st=%0d page=%h idx=%0d entry=%h wr=%b last=%b",
                                 $time, status, table_page, entry_index, entry_value,
                                 entry_written, last_result);
                    end
                end
            end
            if (hold_seen != hold_ask) begin
                hold_seen <= hold_ask;
                hold_left <= LONG_HOLD;
                out_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end else
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("page_table_map_insert_unit verification failed");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        levels_reg = 3;
        root_pg = '0;
        has_root = 0;
        foreach (pool_used[i]) begin
            pool_used[i] = 0;
            pool_base[i] = '0;
        end
        foreach (n_status[i])
            n_status[i] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // The 4 KiB pool straddles the top of the address space.
        write_reg(REG_LEVELS, 3);
        write_reg(REG_BASE0, 44'hfff_ffff_ffff);
        write_reg(REG_BASE1, 44'h0);
        write_reg(REG_BASE2, 44'hfff_ffff_ffff);
        write_reg(REG_BASE3, CFG_W'({$urandom, $urandom}));
        write_reg(REG_BASE4, CFG_W'({$urandom, $urandom}));

        queue_req(mk_req(CMD_MAP_GIVEN, 45'h5, 44'h7, 0, 7));
        queue_req(mk_req(CMD_UNUSED, '1, '1, 7, 7));
        queue_req(mk_req(CMD_MAP_GIVEN, 45'h5, 44'h7, 7, 0));
        queue_req(mk_req(CMD_NEW_ROOT, '0, '0, 0, 0));
        queue_req(mk_req(CMD_MAP_GIVEN, '0, '0, 0, 0));
        queue_req(mk_req(CMD_MAP_GIVEN, '1, '1, 0, 7));
        queue_req(mk_req(CMD_MAP_GIVEN, 45'h200, 44'h5a5_a5a5_a5a5, 1, 5));
        // A leaf far outside the store, then a smaller page below it.
        queue_req(mk_req(CMD_MAP_GIVEN, 45'h5 << 18, 44'h123_4567_89ab, 2, 2));
        queue_req(mk_req(CMD_MAP_GIVEN, (45'h5 << 18) | 45'h3, 44'h1, 0, 1));
        queue_req(mk_req(CMD_MAP_GIVEN, 45'h1, 44'h1, 3, 1));
        queue_req(mk_req(CMD_MAP_ALLOC, 45'h1, '0, 0, 3));
        queue_req(mk_req(CMD_MAP_ALLOC, 45'h400, '0, 1, 6));
        queue_req(mk_req(CMD_MAP_ALLOC, 45'h4 << 18, '0, 2, 4));
        for (int i = 0; i < 8; i++)
            queue_req(mk_req(CMD_MAP_GIVEN, 45'h10 + i, 44'h100 + i, 0, i));
        queue_random(20);
        hold_ask++;
        drain();

        queue_random(80);
        drain();

        write_reg(REG_LEVELS, 4);
        send_idle_pct = 75;
        queue_random(90);
        drain();

        write_reg(REG_LEVELS, 5);
        write_reg(REG_BASE1, 44'hfff_ffff_ffff);
        write_reg(REG_BASE2, 44'h0);
        send_idle_pct = 0;
        recv_stall_pct = 75;
        queue_random(90);
        drain();

        write_reg(REG_LEVELS, 7);
        write_reg(REG_BASE3, 44'hfff_ffff_ffff);
        write_reg(REG_BASE4, 44'h0);
        send_idle_pct = 34;
        recv_stall_pct = 34;
        queue_random(80);
        drain();

        // Moving the pool puts the frame at the old base outside the store and shifts the others.
        write_reg(REG_LEVELS, 0);
        write_reg(REG_BASE0, 44'h0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_random(70);
        drain();

        $display("Sent %0d commands over levels 3 to 5, got %0d results", n_sent, n_results);
        $display("Status counts: ok %0d, exhausted %0d, level %0d, outside %0d",
                 n_status[0], n_status[1], n_status[2], n_status[3]);
        if (errors == 0)
            $display("page_table_map_insert_unit verification clean");
        else
            $display("page_table_map_insert_unit verification failed");
        $finish;
    end

endmodule
